### src/swps_pkg.sv
// ----------------------------------------------------------------------------
// swps_pkg
// Types and constants shared by the spot weld pulse sequencer modules.
// ----------------------------------------------------------------------------
package swps_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_MAINS_FREQ  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREHEAT_HC  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_HC      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WELD_HC     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAFE_INTVL  = 3'd5;

    // sequence phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PREHEAT = 2'd1;
    localparam logic [1:0] PH_GAP     = 2'd2;
    localparam logic [1:0] PH_MAIN    = 2'd3;

    localparam int unsigned MS_PER_SECOND = 1000;
    localparam int unsigned DIVIDEND_W    = 18;  // 255 * 1000 fits
    localparam int unsigned DIVISOR_W     = 8;   // 2 * 127 fits
    localparam int unsigned LENGTH_W      = 17;
    localparam int unsigned STEADY_W      = 11;
    localparam int unsigned SINCE_W       = 16;

    typedef struct packed {
        logic button_level;
        logic remote_request;
    } in_item_t;

    typedef struct packed {
        logic       weld_drive;
        logic       busy_res;
        logic [1:0] phase;
        logic       weld_done;
        logic       request_pending;
    } out_item_t;

    // classified tick handed from the front to the sequencer
    typedef struct packed {
        logic press;
        logic remote;
    } tick_ev_t;

    typedef struct packed {
        logic [6:0]  mains_frequency;
        logic [7:0]  preheat_half_cycles;
        logic [7:0]  gap_half_cycles;
        logic [7:0]  weld_half_cycles;
        logic [9:0]  debounce_ticks;
        logic [15:0] safe_interval_ticks;
    } cfg_t;

    typedef struct packed {
        logic       start;
        logic [7:0] half_cycles;
        logic [6:0] mains_frequency;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [LENGTH_W-1:0] length;
    } div_rsp_t;

endpackage

### src/swps_front.sv
// ----------------------------------------------------------------------------
// swps_front
// Accepts ticks, debounces the trigger level and queues a press/remote event.
// ----------------------------------------------------------------------------
module swps_front
    import swps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  logic [9:0] debounce_ticks,
    input  logic     q_full,
    output logic     push,
    output tick_ev_t push_data
);

    logic                last_raw_reg;
    logic                last_raw_next;
    logic                stable_reg;
    logic                stable_next;
    logic [STEADY_W-1:0] steady_reg;
    logic [STEADY_W-1:0] steady_next;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        stable_next     = stable_reg;
        push_data.press = 1'b0;
        push_data.remote = in_data.remote_request;
        last_raw_next   = in_data.button_level;
        if (in_data.button_level != last_raw_reg)
        begin
            steady_next = '0;
        end
        else if (steady_reg != {STEADY_W{1'b1}})
        begin
            steady_next = steady_reg + 1'b1;
        end
        else
        begin
            steady_next = steady_reg;
        end
        if (steady_next > {1'b0, debounce_ticks} && in_data.button_level != stable_reg)
        begin
            stable_next     = in_data.button_level;
            push_data.press = !in_data.button_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= 1'b1;
            stable_reg   <= 1'b1;
            steady_reg   <= '0;
        end
        else if (push)
        begin
            last_raw_reg <= last_raw_next;
            stable_reg   <= stable_next;
            steady_reg   <= steady_next;
        end
    end

endmodule

### src/swps_queue.sv
// ----------------------------------------------------------------------------
// swps_queue
// Short event queue between the debounce front and the sequencer.
// ----------------------------------------------------------------------------
module swps_queue
    import swps_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  tick_ev_t push_data,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output tick_ev_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tick_ev_t           mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### src/swps_div.sv
// ----------------------------------------------------------------------------
// swps_div
// Phase length unit: half_cycles*1000 / (2*mains_frequency), one bit a cycle.
// ----------------------------------------------------------------------------
module swps_div
    import swps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] num_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [6:0]            freq_eff;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // zero frequency runs as 1 Hz
    assign freq_eff = (req.mains_frequency == '0) ? 7'd1 : req.mains_frequency;
    assign trial    = {rem_reg, num_reg[DIVIDEND_W-1]};
    assign fits     = (trial >= {1'b0, den_reg});

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.length = quo_reg[LENGTH_W-1:0];

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= DIVIDEND_W'(req.half_cycles) * DIVIDEND_W'(MS_PER_SECOND);
            den_reg <= {freq_eff, 1'b0};
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIVIDEND_W-2:0], 1'b0};
            rem_reg <= fits ? DIVISOR_W'(trial - {1'b0, den_reg}) : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### src/swps_back.sv
// ----------------------------------------------------------------------------
// swps_back
// Weld sequencer: runs phases, arms welds and holds the result register.
// ----------------------------------------------------------------------------
module swps_back
    import swps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_not_empty,
    input  tick_ev_t  q_head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    typedef enum logic
    {
        ST_READY,
        ST_WAIT_LEN
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                armed_reg;
    logic                armed_next;
    logic [SINCE_W-1:0]  since_reg;
    logic [SINCE_W-1:0]  since_next;
    logic [1:0]          phase_reg;
    logic [1:0]          phase_next;
    logic [LENGTH_W-1:0] rem_reg;
    logic [LENGTH_W-1:0] rem_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_data_reg;
    out_item_t           out_data_next;

    logic                done;
    logic [2:0]          search_from;
    logic                do_search;
    logic [1:0]          found;
    logic [LENGTH_W-1:0] rem_dec;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // a phase of zero half cycles has zero length, any other is at least 3 ms
    function automatic logic [1:0] first_phase(input logic [2:0] from, input cfg_t c);
        logic [1:0] ph;
        begin
            ph = PH_IDLE;
            if (from <= 3'd1 && c.preheat_half_cycles != '0)
            begin
                ph = PH_PREHEAT;
            end
            else if (from <= 3'd2 && c.gap_half_cycles != '0)
            begin
                ph = PH_GAP;
            end
            else if (from <= 3'd3 && c.weld_half_cycles != '0)
            begin
                ph = PH_MAIN;
            end
            return ph;
        end
    endfunction

    swps_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign pop       = (state_reg == ST_READY) && q_not_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign rem_dec   = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;

    always_comb
    begin
        state_next     = state_reg;
        armed_next     = armed_reg;
        since_next     = since_reg;
        phase_next     = phase_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        done           = 1'b0;
        do_search      = 1'b0;
        found          = PH_IDLE;
        search_from    = {1'b0, phase_reg} + 3'd1;
        div_req.start  = 1'b0;
        div_req.mains_frequency = cfg.mains_frequency;
        div_req.half_cycles     = cfg.weld_half_cycles;

        unique case (state_reg)
            ST_READY:
            begin
                if (pop)
                begin
                    since_next = (since_reg != {SINCE_W{1'b1}}) ? since_reg + 1'b1 : since_reg;
                    if (phase_reg != PH_IDLE)
                    begin
                        rem_next  = rem_dec;
                        do_search = (rem_dec == '0);
                    end
                    else if (armed_reg)
                    begin
                        armed_next  = 1'b0;
                        do_search   = 1'b1;
                        search_from = 3'd1;
                    end
                    found = first_phase(search_from, cfg);
                    if (do_search)
                    begin
                        phase_next = found;
                        if (found == PH_IDLE)
                        begin
                            done       = 1'b1;
                            rem_next   = '0;
                            since_next = '0;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = ST_WAIT_LEN;
                        end
                    end
                    if ((q_head.press || q_head.remote) && !armed_next && phase_next == PH_IDLE &&
                        since_next > cfg.safe_interval_ticks)
                    begin
                        armed_next = 1'b1;
                    end
                    out_valid_next                = 1'b1;
                    out_data_next.weld_drive      = (phase_next == PH_PREHEAT) ||
                                                    (phase_next == PH_MAIN);
                    out_data_next.busy_res        = (phase_next != PH_IDLE);
                    out_data_next.phase           = phase_next;
                    out_data_next.weld_done       = done;
                    out_data_next.request_pending = armed_next;
                end
            end
            ST_WAIT_LEN:
            begin
                if (div_rsp.done)
                begin
                    rem_next   = div_rsp.length;
                    state_next = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase

        case (phase_next)
            PH_PREHEAT: div_req.half_cycles = cfg.preheat_half_cycles;
            PH_GAP:     div_req.half_cycles = cfg.gap_half_cycles;
            default:    div_req.half_cycles = cfg.weld_half_cycles;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            armed_reg     <= 1'b0;
            since_reg     <= '0;
            phase_reg     <= PH_IDLE;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            since_reg     <= since_next;
            phase_reg     <= phase_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // a running phase always has time left once its length is known
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READY && phase_reg != PH_IDLE) |-> (rem_reg != '0))
        else $error("running phase with zero remaining length");

    a_armed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> (phase_reg == PH_IDLE))
        else $error("weld armed while a sequence runs");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("length unit started while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.weld_done) |->
        (out_data_reg.phase == PH_IDLE && !out_data_reg.weld_drive))
        else $error("weld done reported outside idle");

endmodule

### src/spot_weld_pulse_sequencer_top.sv
// throughput: 1 tick per cycle while the output is taken; a tick that enters a phase holds
//   the next tick while the 18-step length divider runs
// reset: asynchronous, active low; configuration returns to its defaults,
//   debounce sees the button released, no weld is armed or running
// ----------------------------------------------------------------------------
// spot_weld_pulse_sequencer_top
// Dual pulse spot weld timer advanced by one millisecond tick per item.
// ----------------------------------------------------------------------------
module spot_weld_pulse_sequencer_top
    import swps_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t     cfg_reg;
    logic     q_full;
    logic     q_not_empty;
    logic     push;
    logic     pop;
    tick_ev_t push_data;
    tick_ev_t q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mains_frequency     <= 7'd50;
            cfg_reg.preheat_half_cycles <= 8'd2;
            cfg_reg.gap_half_cycles     <= 8'd10;
            cfg_reg.weld_half_cycles    <= 8'd10;
            cfg_reg.debounce_ticks      <= 10'd50;
            cfg_reg.safe_interval_ticks <= 16'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAINS_FREQ: cfg_reg.mains_frequency     <= cfg_data[6:0];
                CFG_PREHEAT_HC: cfg_reg.preheat_half_cycles <= cfg_data[7:0];
                CFG_GAP_HC:     cfg_reg.gap_half_cycles     <= cfg_data[7:0];
                CFG_WELD_HC:    cfg_reg.weld_half_cycles    <= cfg_data[7:0];
                CFG_DEBOUNCE:   cfg_reg.debounce_ticks      <= cfg_data[9:0];
                CFG_SAFE_INTVL: cfg_reg.safe_interval_ticks <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    swps_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .q_full         (q_full),
        .push           (push),
        .push_data      (push_data)
    );

    swps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    swps_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule
